FILE: hdl/assert_macros.svh
// Assertion macros shared by the slice index normalizer RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SIDXN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sidxn assertion failed");
`define SIDXN_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("sidxn forbidden condition");
`else
`define SIDXN_ASSERT(lbl, clk, rst_n, prop)
`define SIDXN_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

FILE: hdl/sidxn_pkg.sv
// Shared types and constants of the slice index normalizer.
// No dependencies.
`default_nettype none
package sidxn_pkg;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_STEP_ZERO = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;
endpackage
`default_nettype wire

FILE: hdl/sidxn_front.sv
// Front end: accepts slice transactions, resolves defaults, wraps and clamps
// bounds, and registers a classified record. Depends on sidxn_pkg.
`default_nettype none
module sidxn_front #(
  parameter int W  = 32,
  parameter int PW = 4 * W + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [W-1:0]          slice_start_i,
  input  wire logic [W-1:0]          slice_stop_i,
  input  wire logic [W-1:0]          slice_step_i,
  input  wire logic                  start_given_i,
  input  wire logic                  stop_given_i,
  input  wire logic                  step_given_i,
  input  wire logic [W-2:0]          sequence_length_i,
  input  wire sidxn_pkg::qstat_t     qstat_i,
  output logic                       push_o,
  output logic [PW-1:0]              rec_o
);
  logic          fv_q, fv_d;
  logic [PW-1:0] rec_q;
  logic [PW-1:0] rec_d;
  logic          accept;

  function automatic logic signed [W:0] clampb(input logic given,
                                              input logic signed [W:0] v,
                                              input logic signed [W:0] lenx,
                                              input logic fwd,
                                              input logic is_start);
    logic signed [W:0] lo;
    logic signed [W:0] up;
    logic signed [W:0] s;
    lo = fwd ? '0 : '1;
    up = fwd ? lenx : (lenx - {{W{1'b0}}, 1'b1});
    s  = v + lenx;
    if (!given) begin
      clampb = (is_start == fwd) ? lo : up;
    end else if (v[W]) begin
      clampb = s[W] ? lo : s;
    end else if (v >= up) begin
      clampb = up;
    end else begin
      clampb = v;
    end
  endfunction

  always_comb begin
    logic [W-1:0]      stp;
    logic              zero;
    logic              fwd;
    logic [W-1:0]      mag;
    logic signed [W:0] lenx;
    logic signed [W:0] first;
    logic signed [W:0] last;
    logic              ne;
    logic [W:0]        diff;
    logic [W:0]        dm1;
    stp   = step_given_i ? slice_step_i : {{(W-1){1'b0}}, 1'b1};
    zero  = (stp == '0);
    fwd   = !stp[W-1];
    mag   = fwd ? stp : ('0 - stp);
    lenx  = signed'({2'b00, sequence_length_i});
    first = clampb(start_given_i, signed'({slice_start_i[W-1], slice_start_i}),
                   lenx, fwd, 1'b1);
    last  = clampb(stop_given_i, signed'({slice_stop_i[W-1], slice_stop_i}),
                   lenx, fwd, 1'b0);
    ne    = fwd ? (first < last) : (first > last);
    diff  = fwd ? (last - first) : (first - last);
    dm1   = diff - {{W{1'b0}}, 1'b1};
    rec_d = {zero, ne, first[W-1:0], last[W-1:0], mag, dm1[W-2:0]};
  end

  assign in_stall_o = fv_q && qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign fv_d       = accept || (fv_q && qstat_i.full);
  assign push_o     = fv_q;
  assign rec_o      = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec_q <= rec_d;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/sidxn_queue.sv
// Two-entry queue between front and back of the slice index normalizer.
// Depends on sidxn_pkg.
`default_nettype none
module sidxn_queue #(
  parameter int PW = 129
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [PW-1:0]     data_i,
  input  wire logic              pop_i,
  output logic [PW-1:0]          data_o,
  output sidxn_pkg::qstat_t      qstat_o
);
  logic [PW-1:0] mem_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign qstat_o.full  = (cnt_q == 2'd2);
  assign qstat_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign data_o  = mem_q[rd_q];
  assign wr_d    = wr_q ^ do_push;
  assign rd_d    = rd_q ^ do_pop;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/sidxn_back.sv
// Back end: pipelined restoring divider (one quotient bit per stage) for the
// element count, plus the result register. Depends on sidxn_pkg.
`default_nettype none
module sidxn_back #(
  parameter int W  = 32,
  parameter int PW = 4 * W + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sidxn_pkg::qstat_t qstat_i,
  input  wire logic [PW-1:0]     rec_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   status_o,
  output logic [W-1:0]           norm_start_o,
  output logic [W-1:0]           norm_stop_o,
  output logic [W-1:0]           step_magnitude_o,
  output logic [W-2:0]           slice_length_o
);
  localparam int N = W - 1;

  logic         vld_q   [N+1];
  logic         zero_q  [N+1];
  logic         ne_q    [N+1];
  logic [W-1:0] first_q [N+1];
  logic [W-1:0] last_q  [N+1];
  logic [W-1:0] mag_q   [N+1];
  logic [N-1:0] num_q   [N+1];
  logic [N-1:0] rem_q   [N+1];
  logic [N-1:0] quo_q   [N+1];

  logic         en;
  logic         ov_q;
  logic         st_q;
  logic [W-1:0] fs_q, ls_q, mg_q;
  logic [N-1:0] len_q;

  assign en    = !ov_q || !out_stall_i;
  assign pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= !qstat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      {zero_q[0], ne_q[0], first_q[0], last_q[0], mag_q[0], num_q[0]} <= rec_i;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0] t;
    logic         ge;
    logic [W-1:0] r;
    assign t  = {rem_q[k], num_q[k][N-1]};
    assign ge = (t >= mag_q[k]);
    assign r  = ge ? (t - mag_q[k]) : t;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        zero_q[k+1]  <= zero_q[k];
        ne_q[k+1]    <= ne_q[k];
        first_q[k+1] <= first_q[k];
        last_q[k+1]  <= last_q[k];
        mag_q[k+1]   <= mag_q[k];
        num_q[k+1]   <= {num_q[k][N-2:0], 1'b0};
        rem_q[k+1]   <= r[N-1:0];
        quo_q[k+1]   <= {quo_q[k][N-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[N]) begin
      if (zero_q[N]) begin
        st_q  <= sidxn_pkg::STATUS_STEP_ZERO;
        fs_q  <= '0;
        ls_q  <= '0;
        mg_q  <= '0;
        len_q <= '0;
      end else begin
        st_q  <= sidxn_pkg::STATUS_OK;
        fs_q  <= first_q[N];
        ls_q  <= last_q[N];
        mg_q  <= mag_q[N];
        len_q <= ne_q[N] ? (quo_q[N] + {{(N-1){1'b0}}, 1'b1}) : '0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign norm_start_o     = fs_q;
  assign norm_stop_o      = ls_q;
  assign step_magnitude_o = mg_q;
  assign slice_length_o   = len_q;
endmodule
`default_nettype wire

FILE: hdl/slice_index_normalizer.sv
// Slice index normalizer top level: front, queue and divider back end.
// Depends on sidxn_pkg, sidxn_front, sidxn_queue, sidxn_back, assert_macros.svh.
//
// Usage: one transaction on the input channel (in_valid_i / in_stall_o)
// carries a slice and a sequence length; one transaction on the output
// channel (out_valid_o / out_stall_i) returns status, normalized start and
// stop, step magnitude and element count, in input order.
// Pipeline from input acceptance to out_valid_o: front register, queue,
// queue-to-divider load, INDEX_BITS-1 divider stages, result register.
// Throughput: one transaction per cycle while out_stall_i is low, set by
// the fully pipelined restoring divider that yields one quotient bit per stage.
// Reset clears all valid flags and the queue; no transaction is in flight
// afterwards. When the receiver stalls, the divider pipeline freezes, the
// two-entry queue fills, and in_stall_o rises once the front register
// cannot drain into the queue.
// A zero step returns status 1 with all other fields zero.
`default_nettype none
`include "assert_macros.svh"
module slice_index_normalizer #(
  parameter int INDEX_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [INDEX_BITS-1:0] slice_start_i,
  input  wire logic [INDEX_BITS-1:0] slice_stop_i,
  input  wire logic [INDEX_BITS-1:0] slice_step_i,
  input  wire logic                  start_given_i,
  input  wire logic                  stop_given_i,
  input  wire logic                  step_given_i,
  input  wire logic [INDEX_BITS-2:0] sequence_length_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       status_o,
  output logic [INDEX_BITS-1:0]      norm_start_o,
  output logic [INDEX_BITS-1:0]      norm_stop_o,
  output logic [INDEX_BITS-1:0]      step_magnitude_o,
  output logic [INDEX_BITS-2:0]      slice_length_o
);
  localparam int PW = 4 * INDEX_BITS + 1;

  sidxn_pkg::qstat_t qstat;
  logic              push;
  logic              pop;
  logic [PW-1:0]     rec_in;
  logic [PW-1:0]     rec_out;

  sidxn_front #(.W(INDEX_BITS), .PW(PW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .slice_start_i, .slice_stop_i, .slice_step_i,
    .start_given_i, .stop_given_i, .step_given_i, .sequence_length_i,
    .qstat_i (qstat),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  sidxn_queue #(.PW(PW)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (rec_in),
    .pop_i   (pop),
    .data_o  (rec_out),
    .qstat_o (qstat)
  );

  sidxn_back #(.W(INDEX_BITS), .PW(PW)) u_back (
    .clk_i, .rst_ni,
    .qstat_i (qstat),
    .rec_i   (rec_out),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i, .status_o,
    .norm_start_o, .norm_stop_o, .step_magnitude_o, .slice_length_o
  );

  `SIDXN_ASSERT(a_zero_step_clean, clk_i, rst_ni, (out_valid_o && status_o) |-> (norm_start_o == '0 && norm_stop_o == '0 && step_magnitude_o == '0 && slice_length_o == '0))
  `SIDXN_NEVER(a_ok_mag_nonzero, clk_i, rst_ni, out_valid_o && !status_o && step_magnitude_o == '0)
  `SIDXN_ASSERT(a_empty_when_equal, clk_i, rst_ni, (out_valid_o && norm_start_o == norm_stop_o) |-> (slice_length_o == '0))
endmodule
`default_nettype wire

FILE: tb/slice_index_normalizer_tb.sv
// Testbench for slice_index_normalizer: Python slice index normalization.
// Depends on sidxn_pkg and the slice_index_normalizer RTL; a built-in
// predictor computes each expected transaction and a monitor compares.
`default_nettype none
module slice_index_normalizer_tb;

  localparam int W = 32;
  localparam int LATENCY = W + 2;

  typedef struct packed {
    logic         status;
    logic [W-1:0] first_idx;
    logic [W-1:0] end_idx;
    logic [W-1:0] stride;
    logic [W-2:0] count;
  } slice_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] slice_start_i = '0;
  logic [W-1:0] slice_stop_i = '0;
  logic [W-1:0] slice_step_i = '0;
  logic         start_given_i = 1'b0;
  logic         stop_given_i = 1'b0;
  logic         step_given_i = 1'b0;
  logic [W-2:0] sequence_length_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic         status_o;
  logic [W-1:0] norm_start_o;
  logic [W-1:0] norm_stop_o;
  logic [W-1:0] step_magnitude_o;
  logic [W-2:0] slice_length_o;

  slice_result_t expected_slices[$];
  int  mismatch_count = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_gaps = 1'b1;
  bit  hold_receiver = 1'b0;
  int  hold_cycles = 0;

  slice_index_normalizer #(.INDEX_BITS(W)) dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint bound_clamp(bit given, longint value, longint len,
                                         bit forward, bit is_start);
    longint lo, hi;
    lo = forward ? 0 : -1;
    hi = forward ? len : len - 1;
    if (!given) return (is_start == forward) ? lo : hi;
    if (value < 0) begin
      value += len;
      if (value < 0) value = lo;
    end else if (value >= hi) begin
      value = hi;
    end
    return value;
  endfunction

  function automatic slice_result_t normalize_slice(
      logic [W-1:0] s0, logic [W-1:0] s1, logic [W-1:0] st,
      bit hs0, bit hs1, bit hst, logic [W-2:0] len_bits);
    slice_result_t r;
    longint step, len, a, b, span;
    longint unsigned mag;
    longint unsigned q;
    bit fwd;
    r = '0;
    step = hst ? longint'($signed(st)) : 1;
    len = longint'(len_bits);
    if (step == 0) begin
      r.status = sidxn_pkg::STATUS_STEP_ZERO;
      return r;
    end
    fwd = step > 0;
    mag = fwd ? step : -step;
    a = bound_clamp(hs0, longint'($signed(s0)), len, fwd, 1'b1);
    b = bound_clamp(hs1, longint'($signed(s1)), len, fwd, 1'b0);
    span = fwd ? b - a : a - b;
    r.status = sidxn_pkg::STATUS_OK;
    r.first_idx = a[W-1:0];
    r.end_idx = b[W-1:0];
    r.stride = mag[W-1:0];
    if (span > 0) begin
      q = (unsigned'(span) - 1) / mag + 1;
      r.count = q[W-2:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic send_slice(logic [W-1:0] s0, logic [W-1:0] s1, logic [W-1:0] st,
                            bit hs0, bit hs1, bit hst, logic [W-2:0] len);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    slice_start_i <= s0;
    slice_stop_i <= s1;
    slice_step_i <= st;
    start_given_i <= hs0;
    stop_given_i <= hs1;
    step_given_i <= hst;
    sequence_length_i <= len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_slices.push_back(normalize_slice(s0, s1, st, hs0, hs1, hst, len));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall driver
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_receiver) begin
        out_stall_i <= 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 60) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        hold_receiver = 1'b0;
        out_stall_i <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    slice_result_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_slices.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
      end else begin
        w = expected_slices.pop_front();
        if (status_o !== w.status)
          report_mismatch("status", W'(status_o), W'(w.status));
        if (norm_start_o !== w.first_idx)
          report_mismatch("norm_start", norm_start_o, w.first_idx);
        if (norm_stop_o !== w.end_idx) report_mismatch("norm_stop", norm_stop_o, w.end_idx);
        if (step_magnitude_o !== w.stride)
          report_mismatch("step_magnitude", step_magnitude_o, w.stride);
        if (slice_length_o !== w.count)
          report_mismatch("slice_length", W'(slice_length_o), W'(w.count));
      end
    end
  end

  function automatic logic [W-1:0] pick_index(logic [W-2:0] len);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 40);
      2: return -$urandom_range(0, 40);
      3: return {1'b0, len} + $urandom_range(0, 3) - 2;
      4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return -{1'b0, len} + $urandom_range(0, 3) - 2;
    endcase
  endfunction

  task automatic random_slice();
    logic [W-1:0] rnd;
    logic [W-2:0] len;
    logic [W-1:0] st;
    case ($urandom_range(0, 4))
      0: rnd = $urandom;
      1: rnd = 32'h7fff_ffff - $urandom_range(0, 3);
      default: rnd = $urandom_range(0, 50);
    endcase
    len = rnd[W-2:0];
    case ($urandom_range(0, 5))
      0: st = $urandom;
      1: st = 32'h8000_0000;
      2: st = 0;
      default: st = $urandom_range(1, 7) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
    send_slice(pick_index(len), pick_index(len), st, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0, len);
  endtask

  task automatic test_directed();
    send_slice(0, 0, 0, 1, 1, 1, 10);
    send_slice(0, 0, 0, 1, 1, 0, 10);
    send_slice(0, 0, 0, 0, 0, 0, 0);
    send_slice(0, 0, 32'h8000_0000, 0, 0, 1, 31'h7fff_ffff);
    send_slice(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, 31'h7fff_ffff);
    send_slice(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1, 31'h7fff_ffff);
    send_slice(32'h8000_0000, 32'h7fff_ffff, 1, 1, 1, 1, 31'h7fff_ffff);
    send_slice(-3, -1, 1, 1, 1, 1, 10);
    send_slice(-100, 100, 2, 1, 1, 1, 10);
    send_slice(100, -100, -1, 1, 1, 1, 10);
    send_slice(0, 0, -1, 0, 0, 1, 10);
    send_slice(0, 0, -3, 0, 0, 1, 0);
    send_slice(5, 5, 1, 1, 1, 1, 10);
    send_slice(9, 2, 3, 1, 1, 1, 10);
    send_slice(10, 0, -2, 1, 1, 1, 10);
    send_slice(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1, 31'h7fff_ffff);
    send_slice(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 0, 1, 1, 31'h2aaa_aaaa);
    send_slice(32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a988, 1, 0, 1, 31'h5555_5555);
    wait_drained();
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) random_slice();
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_receiver = 1'b1;
    repeat (60) random_slice();
    sender_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_streaming(int n);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    repeat (n) random_slice();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(450);
    wait_drained();
    test_backpressure();
    test_random_traffic(250);
    test_streaming(170);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk_i);
    if (mismatch_count == 0 && expected_slices.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
